// ===== sv/cdq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the circular deque core.
// Depends on nothing; every other file except cdq_ram refers to it by scoped names.

package cdq_pkg;

    // Command codes carried in the input word
    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_REAR  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_REAR   = 2'd3;

    // Status codes carried in the result word
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] push_value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
        logic [3:0]         occupancy;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic push_write;   // store the pushed word, move the pointer, bump the count
        logic pop_read;     // read the popped entry, move the pointer, drop the count
        logic load_direct;  // load the result register with a non-read result
        logic load_read;    // load the result register with the read data
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_full;
        logic is_empty;
        logic out_busy;     // result register holds a word that is not taken this cycle
    } dp_status_t;

endpackage

// ===== sv/cdq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/cdq_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the circular deque: accepts commands and
// sequences the datapath. Depends on cdq_pkg.

module cdq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  logic [1:0]             command,
    input  cdq_pkg::dp_status_t    dp_status,
    output logic                   accept,
    output cdq_pkg::ctrl_cmd_t     ctrl_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic state_reg;
    logic state_next;
    logic is_pop;

    assign is_pop = (command == cdq_pkg::CMD_POP_FRONT) ||
                    (command == cdq_pkg::CMD_POP_REAR);

    assign accept = (state_reg == S_IDLE) && cmd_valid && !dp_status.out_busy;

    always_comb
    begin
        state_next = state_reg;
        ctrl_cmd   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_pop && !dp_status.is_empty)
                    begin
                        ctrl_cmd.pop_read = 1'b1;
                        state_next        = S_READ;
                    end
                    else
                    begin
                        ctrl_cmd.push_write  = !is_pop && !dp_status.is_full;
                        ctrl_cmd.load_direct = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                // read data is ready; result register is free since accept
                ctrl_cmd.load_read = 1'b1;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/cdq_datapath.sv =====
`timescale 1ns / 1ps
// Datapath for the circular deque: pointers, count, word store and result
// register. Depends on cdq_pkg and cdq_ram.

module cdq_datapath #(
    parameter int DEPTH = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cdq_pkg::in_word_t      in_word,
    input  cdq_pkg::ctrl_cmd_t     ctrl_cmd,
    input  logic                   out_stall,
    output cdq_pkg::dp_status_t    dp_status,
    output logic                   out_valid,
    output cdq_pkg::out_word_t     out_word
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    cdq_pkg::out_word_t out_word_reg, out_word_next;

    logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic [PTR_W-1:0] wr_addr, rd_addr;
    logic [31:0]      rd_data;
    logic             is_front, is_pop;
    logic [1:0]       direct_status;

    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? PTR_LAST : head_reg - 1'b1;
    assign tail_inc = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? PTR_LAST : tail_reg - 1'b1;

    assign is_front = (in_word.command == cdq_pkg::CMD_PUSH_FRONT) ||
                      (in_word.command == cdq_pkg::CMD_POP_FRONT);
    assign is_pop   = (in_word.command == cdq_pkg::CMD_POP_FRONT) ||
                      (in_word.command == cdq_pkg::CMD_POP_REAR);

    assign dp_status.is_full  = (count_reg == CNT_FULL);
    assign dp_status.is_empty = (count_reg == '0);
    assign dp_status.out_busy = out_valid_reg && out_stall;

    assign wr_addr = is_front ? head_dec : tail_reg;
    assign rd_addr = is_front ? head_reg : tail_dec;

    cdq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctrl_cmd.push_write),
        .wr_addr (wr_addr),
        .wr_data (in_word.push_value),
        .rd_en   (ctrl_cmd.pop_read),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl_cmd.push_write)
        begin
            count_next = count_reg + 1'b1;
            if (is_front)
            begin
                head_next = head_dec;
            end
            else
            begin
                tail_next = tail_inc;
            end
        end
        else if (ctrl_cmd.pop_read)
        begin
            count_next = count_reg - 1'b1;
            if (is_front)
            begin
                head_next = head_inc;
            end
            else
            begin
                tail_next = tail_dec;
            end
        end
    end

    always_comb
    begin
        if (is_pop)
        begin
            direct_status = dp_status.is_empty ? cdq_pkg::ST_EMPTY : cdq_pkg::ST_OK;
        end
        else
        begin
            direct_status = dp_status.is_full ? cdq_pkg::ST_FULL : cdq_pkg::ST_OK;
        end
    end

    always_comb
    begin
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (ctrl_cmd.load_direct)
        begin
            out_word_next.pop_value = '0;
            out_word_next.status    = direct_status;
            out_word_next.occupancy = 4'(count_next);
            out_valid_next          = 1'b1;
        end
        else if (ctrl_cmd.load_read)
        begin
            out_word_next.pop_value = rd_data;
            out_word_next.status    = cdq_pkg::ST_OK;
            out_word_next.occupancy = 4'(count_reg);
            out_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== sv/circular_deque_core.sv =====
`timescale 1ns / 1ps
// Circular deque core: push/pop at either end of a DEPTH-entry word store.
// A push or a refused pop is loaded straight into the result register; a
// successful pop passes through the registered RAM read, then that register.
// Pushes are taken at 1 word per cycle while the result is not stalled; a
// pop holds off new commands until its read data reaches the result. Reset
// clears pointers, count and result valid; store contents stay undefined until written.

module circular_deque_core #(
    parameter int DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  cdq_pkg::in_word_t  cmd_word,
    // result channel
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cdq_pkg::out_word_t rsp_word
);

    cdq_pkg::ctrl_cmd_t  ctrl_cmd;
    cdq_pkg::dp_status_t dp_status;
    logic                accept;

    // Take a new word only when the controller is idle and the result
    // register is empty or being drained this cycle.
    assign cmd_stall = !accept;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .command   (cmd_word.command),
        .dp_status (dp_status),
        .accept    (accept),
        .ctrl_cmd  (ctrl_cmd)
    );

    // Pointers, count, store and the result register live here.
    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (cmd_word),
        .ctrl_cmd  (ctrl_cmd),
        .out_stall (rsp_stall),
        .dp_status (dp_status),
        .out_valid (rsp_valid),
        .out_word  (rsp_word)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for circular_deque_core: table of directed commands, then random traffic.
// Depends on cdq_pkg (word types, command and status codes) and the core itself.

module testbench;

    localparam int DEPTH        = 8;
    localparam int RANDOM_WORDS = 1200;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 8;     // margin after the owed words are all taken

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    cdq_pkg::in_word_t  cmd_word  = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    cdq_pkg::out_word_t rsp_word;

    circular_deque_core #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_word (cmd_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word (rsp_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow deque: tracks what the core should hold after every accepted
    // command. Entries are only read after a push wrote them.
    // ------------------------------------------------------------------
    logic [31:0] shadow_store [DEPTH];
    int          shadow_head  = 0;
    int          shadow_tail  = 0;
    int          shadow_count = 0;

    // Result words owed by the core, oldest first
    cdq_pkg::out_word_t awaited_words [$];

    int          mismatches  = 0;
    int          words_seen  = 0;
    int          idle_cycles = 0;
    bit          cmd_quiet   = 1'b0;
    bit          rsp_quiet   = 1'b0;

    // Apply one command to the shadow deque and return the word it yields
    function automatic cdq_pkg::out_word_t deque_apply(input cdq_pkg::in_word_t w);
        cdq_pkg::out_word_t r;
        r = '0;
        r.status = cdq_pkg::ST_OK;
        case (w.command)
            cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR:
            begin
                if (shadow_count >= DEPTH)
                    r.status = cdq_pkg::ST_FULL;
                else if (w.command == cdq_pkg::CMD_PUSH_FRONT)
                begin
                    // step head back one slot, wrapping below zero
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_store[shadow_head] = w.push_value;
                    shadow_count++;
                end
                else
                begin
                    shadow_store[shadow_tail] = w.push_value;
                    shadow_tail = (shadow_tail + 1) % DEPTH;
                    shadow_count++;
                end
            end
            default:
            begin
                if (shadow_count == 0)
                    r.status = cdq_pkg::ST_EMPTY;
                else if (w.command == cdq_pkg::CMD_POP_FRONT)
                begin
                    r.pop_value = shadow_store[shadow_head];
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                end
                else
                begin
                    // tail points past the rear entry: step back, then read
                    shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
                    r.pop_value = shadow_store[shadow_tail];
                    shadow_count--;
                end
            end
        endcase
        r.occupancy = 4'(shadow_count);
        return r;
    endfunction

    // Report one mismatch on a single line and count it
    task automatic flag_mismatch(input string what);
        $display("MISMATCH: %s", what);
        mismatches++;
    endtask

    // Offer one command word: wait a random gap, raise valid, hold the word
    // until the core takes it, then record the word the core owes back.
    // A typed answer from the table overrides the shadow deque's answer,
    // but the shadow deque still advances so later rows stay in step.
    task automatic send_word(input cdq_pkg::in_word_t w, input bit typed,
                             input cdq_pkg::out_word_t want);
        int                 gap;
        cdq_pkg::out_word_t predicted;
        gap = cmd_quiet ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_word  <= w;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (cmd_stall);
        predicted = deque_apply(w);
        awaited_words.push_back(typed ? want : predicted);
    endtask

    // ------------------------------------------------------------------
    // Directed table. Typed answers only where they are obvious: empty
    // pops, the fill count on pushes and refused pushes at full. The pops
    // that drain the deque are checked by the shadow deque. Pops carry a
    // junk push_value to show it is ignored.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
        logic        typed;
        logic [31:0] want_value;
        logic [1:0]  want_status;
        logic [3:0]  want_occ;
    } plan_row_t;

    plan_row_t plan [21] = '{
        // empty pops right after reset
        {cdq_pkg::CMD_POP_FRONT,  32'hDEAD_BEEF, 1'b1, 32'h0, cdq_pkg::ST_EMPTY, 4'd0},
        {cdq_pkg::CMD_POP_REAR,   32'hFFFF_FFFF, 1'b1, 32'h0, cdq_pkg::ST_EMPTY, 4'd0},
        // fill from both ends with the extreme words; first front push wraps head
        {cdq_pkg::CMD_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, 32'h0, cdq_pkg::ST_OK,    4'd1},
        {cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'h0, cdq_pkg::ST_OK,    4'd2},
        {cdq_pkg::CMD_PUSH_REAR,  32'hFFFF_FFFF, 1'b1, 32'h0, cdq_pkg::ST_OK,    4'd3},
        {cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0000, 1'b1, 32'h0, cdq_pkg::ST_OK,    4'd4},
        {cdq_pkg::CMD_PUSH_REAR,  32'h5555_5555, 1'b1, 32'h0, cdq_pkg::ST_OK,    4'd5},
        {cdq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, 32'h0, cdq_pkg::ST_OK,    4'd6},
        {cdq_pkg::CMD_PUSH_REAR,  32'h0000_0001, 1'b1, 32'h0, cdq_pkg::ST_OK,    4'd7},
        {cdq_pkg::CMD_PUSH_FRONT, 32'h1234_5678, 1'b1, 32'h0, cdq_pkg::ST_OK,    4'd8},
        // refused pushes at full
        {cdq_pkg::CMD_PUSH_REAR,  32'h0000_0063, 1'b1, 32'h0, cdq_pkg::ST_FULL,  4'd8},
        {cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFB, 1'b1, 32'h0, cdq_pkg::ST_FULL,  4'd8},
        // drain alternating ends
        {cdq_pkg::CMD_POP_FRONT,  32'h0F0F_0F0F, 1'b0, 32'h0, cdq_pkg::ST_OK,    4'd0},
        {cdq_pkg::CMD_POP_REAR,   32'hF0F0_F0F0, 1'b0, 32'h0, cdq_pkg::ST_OK,    4'd0},
        {cdq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, cdq_pkg::ST_OK,    4'd0},
        {cdq_pkg::CMD_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, cdq_pkg::ST_OK,    4'd0},
        {cdq_pkg::CMD_POP_FRONT,  32'hFFFF_FFFF, 1'b0, 32'h0, cdq_pkg::ST_OK,    4'd0},
        {cdq_pkg::CMD_POP_REAR,   32'h8000_0000, 1'b0, 32'h0, cdq_pkg::ST_OK,    4'd0},
        {cdq_pkg::CMD_POP_FRONT,  32'h7FFF_FFFF, 1'b0, 32'h0, cdq_pkg::ST_OK,    4'd0},
        {cdq_pkg::CMD_POP_REAR,   32'h1111_1111, 1'b0, 32'h0, cdq_pkg::ST_OK,    4'd0},
        // empty again after the last pop
        {cdq_pkg::CMD_POP_REAR,   32'h2222_2222, 1'b1, 32'h0, cdq_pkg::ST_EMPTY, 4'd0}
    };

    // ------------------------------------------------------------------
    // Command side: reset, directed table, then random traffic
    // ------------------------------------------------------------------
    initial
    begin : cmd_side
        cdq_pkg::in_word_t  w;
        cdq_pkg::out_word_t want;
        int                 push_pct;
        push_pct = 50;

        // hold reset low, then release it on a falling edge
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(plan); i++)
        begin
            w.command      = plan[i].cmd;
            w.push_value   = plan[i].value;
            want.pop_value = plan[i].want_value;
            want.status    = plan[i].want_status;
            want.occupancy = plan[i].want_occ;
            send_word(w, plan[i].typed, want);
        end

        // Random traffic in bursts. Each burst leans toward pushes, pops or
        // neither, so the occupancy swings between empty and full and the
        // refusals at both ends keep coming up. Some bursts offer words
        // back to back with no gaps.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 30 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
                cmd_quiet = ($urandom_range(0, 3) == 0);
            end
            w.push_value = $urandom;
            if ($urandom_range(1, 100) <= push_pct)
                w.command = $urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_REAR
                                                 : cdq_pkg::CMD_PUSH_FRONT;
            else
                w.command = $urandom_range(0, 1) ? cdq_pkg::CMD_POP_REAR
                                                 : cdq_pkg::CMD_POP_FRONT;
            send_word(w, 1'b0, '0);
        end

        // drop valid and let the core drain everything it owes
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (awaited_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: before each result, hold stall for a random number of
    // cycles, then release and wait for the next word to be taken. Some
    // stretches take results with no stall at all.
    // ------------------------------------------------------------------
    initial
    begin : rsp_side
        int hold;
        int served;
        served = 0;
        @(posedge rst_n);
        forever
        begin
            if (served % 40 == 0)
                rsp_quiet = ($urandom_range(0, 3) == 0);
            hold = rsp_quiet ? 0 : $urandom_range(0, 14);
            @(negedge clk);
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
            served++;
        end
    end

    // Check every taken result word against the oldest owed one
    always @(posedge clk)
    begin : check_rsp
        cdq_pkg::out_word_t due;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_words.size() == 0)
                flag_mismatch($sformatf("word %0d arrived with none owed", words_seen));
            else
            begin
                due = awaited_words.pop_front();
                if (rsp_word.pop_value !== due.pop_value)
                    flag_mismatch($sformatf("word %0d pop_value got %0d want %0d",
                                            words_seen, rsp_word.pop_value, due.pop_value));
                if (rsp_word.status !== due.status)
                    flag_mismatch($sformatf("word %0d status got %0d want %0d",
                                            words_seen, rsp_word.status, due.status));
                if (rsp_word.occupancy !== due.occupancy)
                    flag_mismatch($sformatf("word %0d occupancy got %0d want %0d",
                                            words_seen, rsp_word.occupancy, due.occupancy));
            end
            words_seen++;
        end
    end

    // Watchdog: end the run if neither channel moves a word for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
sv/cdq_pkg.sv
sv/cdq_ram.sv
sv/cdq_ctrl.sv
sv/cdq_datapath.sv
sv/circular_deque_core.sv
test/testbench.sv
